@@ rtl/rqg_pkg.sv @@
// rqg_pkg: shared types and constants for the rayleigh quotient gradient block
// no dependencies
`default_nettype none
package rqg_pkg;

    localparam int MAX_DIM_DEF = 16;
    localparam int NCELL       = 16;   // coefficient cells in the ring
    localparam int TW          = 36;   // row product t_j, Q.30
    localparam int QW          = 56;   // quadratic form q, Q.45
    localparam int VW          = 35;   // norm n, Q.30, unsigned
    localparam int RW          = 37;   // ratio q/n, Q.30
    localparam int NW          = 53;   // gradient numerator, Q.45
    localparam int DW          = 71;   // divider dividend and quotient

    localparam logic REQ_MATRIX = 1'b0;
    localparam logic REQ_VECTOR = 1'b1;

    typedef struct packed {
        logic               req_type;
        logic [3:0]         row_index;
        logic [3:0]         col_index;
        logic signed [15:0] matrix_value;
        logic signed [15:0] vector_value;
    } in_word_t;

    typedef struct packed {
        logic [3:0]         element_index;
        logic signed [31:0] gradient_value;
        logic signed [31:0] objective_value;
        logic               zero_norm;
        logic               last_result;
    } out_word_t;

    typedef struct packed {
        logic          start;
        logic [DW-1:0] dividend;
        logic [VW-1:0] divisor;
    } div_req_t;

endpackage
`default_nettype wire

@@ rtl/rqg_cell.sv @@
// rqg_cell: one ring cell holding a coefficient and a row product
// depends on rqg_pkg
`default_nettype none
module rqg_cell (
    input  logic                           clk,
    input  logic                           a_en,
    input  logic signed [15:0]             a_in,
    input  logic                           t_en,
    input  logic signed [rqg_pkg::TW-1:0]  t_in,
    output logic signed [15:0]             a_out,
    output logic signed [rqg_pkg::TW-1:0]  t_out
);
    import rqg_pkg::*;

    logic signed [15:0]   a_reg;
    logic signed [TW-1:0] t_reg;

    always_ff @(posedge clk)
    begin
        if (a_en)
        begin
            a_reg <= a_in;
        end
        if (t_en)
        begin
            t_reg <= t_in;
        end
    end

    assign a_out = a_reg;
    assign t_out = t_reg;
endmodule
`default_nettype wire

@@ rtl/rqg_div.sv @@
// rqg_div: restoring divider, one quotient bit per cycle
// depends on rqg_pkg
`default_nettype none
module rqg_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  rqg_pkg::div_req_t           req,
    output logic                        done,
    output logic [rqg_pkg::DW-1:0]      quot
);
    import rqg_pkg::*;

    localparam int CW = $clog2(DW);

    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic [VW-1:0] rem_reg;
    logic [VW-1:0] dsr_reg;
    logic [DW-1:0] quo_reg;
    logic [VW:0]   rem_s;
    logic          ge;
    logic [VW:0]   rem_next;

    always_comb
    begin
        rem_s    = {rem_reg, quo_reg[DW-1]};
        ge       = rem_s >= {1'b0, dsr_reg};
        rem_next = ge ? rem_s - {1'b0, dsr_reg} : rem_s;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            dsr_reg  <= '0;
            quo_reg  <= '0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            dsr_reg  <= req.divisor;
            quo_reg  <= req.dividend;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next[VW-1:0];
            quo_reg <= {quo_reg[DW-2:0], ge};
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CW'(DW - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    assign done = done_reg;
    assign quot = quo_reg;
endmodule
`default_nettype wire

@@ rtl/rayleigh_quotient_gradient_top.sv @@
// rayleigh_quotient_gradient_top: overlap matrix store, coefficient ring, control
// depends on rqg_pkg, rqg_cell, rqg_div
//
//   port group   direction  handshake            word
//   cfg          in         cfg_write            cfg_data (vector_length)
//   in           in         in_valid/in_ready    in_data (rqg_pkg::in_word_t)
//   out          out        out_valid/out_ready  out_data (rqg_pkg::out_word_t)
//
// one word at a time; an in-range matrix word also writes its mirror position in S_WR2
// after the last coefficient of a run of L come L*L matrix-vector steps through the
// single memory read port, then, unless the norm is zero, the shared divider rotates its
// 71-bit dividend once for q/n and once per gradient element
// reset spares memory and ring cells; out_ready low holds the pending result and the run
`default_nettype none
module rayleigh_quotient_gradient_top #(
    parameter int MAX_DIM = rqg_pkg::MAX_DIM_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic [4:0]         cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  rqg_pkg::in_word_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output rqg_pkg::out_word_t out_data
);
    import rqg_pkg::*;

    localparam int LIM   = (MAX_DIM < NCELL) ? MAX_DIM : NCELL;
    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef enum logic [3:0] {
        S_IDLE, S_WR2, S_MAC, S_QSUM, S_RDIV, S_RWAIT, S_GMUL, S_GNUM, S_GWAIT, S_GOUT
    } state_t;

    function automatic logic [AW-1:0] mat_addr(input logic [3:0] r, input logic [3:0] c);
        mat_addr = AW'(int'(r) * MAX_DIM + int'(c));
    endfunction

    state_t               state_reg;
    logic [4:0]           vlen_reg;
    logic [4:0]           count_reg;
    logic [3:0]           j_reg;
    logic [3:0]           k_reg;
    logic [3:0]           row_reg;
    logic [3:0]           col_reg;
    logic signed [15:0]   mval_reg;
    logic signed [TW-1:0] acc_reg;
    logic [VW-1:0]        n_reg;
    logic signed [QW-1:0] q_reg;
    logic signed [RW-1:0] r_reg;
    logic signed [31:0]   f_reg;
    logic signed [NW-1:0] ar_reg;
    logic                 neg_reg;
    logic signed [31:0]   g_reg;
    logic                 zero_reg;
    logic                 out_valid_reg;
    out_word_t            out_data_reg;

    logic signed [15:0]   mem [DEPTH];
    logic signed [15:0]   rd_data_reg;

    logic [4:0]           len;
    logic [3:0]           last_idx;
    logic [3:0]           head_idx;
    logic                 accept;
    logic                 is_mat;
    logic                 in_range;
    logic [4:0]           cnt_eff;
    logic                 run_start;
    logic                 out_load;
    logic                 row_done;

    logic                 mem_we;
    logic [AW-1:0]        mem_wa;
    logic signed [15:0]   mem_wd;
    logic [3:0]           rd_j;
    logic [3:0]           rd_k;

    logic signed [15:0]   a_cell [NCELL];
    logic signed [TW-1:0] t_cell [NCELL];
    logic signed [15:0]   a_head;
    logic signed [TW-1:0] t_head;
    logic                 a_en;
    logic                 t_en;
    logic signed [15:0]   a_tail;
    logic signed [TW-1:0] t_tail;

    logic signed [31:0]   prod_sa;
    logic signed [31:0]   prod_aa;
    logic signed [TW-1:0] acc_sum;
    logic signed [TW+15:0] prod_at;
    logic [QW-1:0]        q_abs;
    logic signed [RW-1:0] r_new;
    logic signed [RW:0]   f_wide;
    logic signed [31:0]   f_sat;
    logic signed [NW-1:0] num;
    logic [NW-1:0]        num_abs;
    logic signed [31:0]   g_sat;

    div_req_t             div_req;
    logic                 div_done;
    logic [DW-1:0]        div_quot;

    always_comb
    begin
        if (vlen_reg == 5'd0)
        begin
            len = 5'd1;
        end
        else if (vlen_reg > 5'(LIM))
        begin
            len = 5'(LIM);
        end
        else
        begin
            len = vlen_reg;
        end
    end

    assign last_idx  = 4'(len - 5'd1);
    assign head_idx  = 4'(5'(NCELL) - len);
    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign is_mat    = (in_data.req_type == REQ_MATRIX);
    assign in_range  = (int'(in_data.row_index) < MAX_DIM) && (int'(in_data.col_index) < MAX_DIM);
    assign cnt_eff   = (count_reg >= len) ? len - 5'd1 : count_reg;
    assign run_start = accept && !is_mat && (cnt_eff + 5'd1 == len);
    assign out_load  = (state_reg == S_GOUT) && (!out_valid_reg || out_ready);
    assign row_done  = (state_reg == S_MAC) && (k_reg == last_idx);

    // overlap matrix memory, both mirror positions written on consecutive cycles
    assign mem_we = (accept && is_mat && in_range) || (state_reg == S_WR2);
    assign mem_wa = (state_reg == S_WR2) ? mat_addr(col_reg, row_reg)
                                         : mat_addr(in_data.row_index, in_data.col_index);
    assign mem_wd = (state_reg == S_WR2) ? mval_reg : in_data.matrix_value;

    always_comb
    begin
        rd_j = '0;
        rd_k = '0;
        if (state_reg == S_MAC)
        begin
            if (k_reg == last_idx)
            begin
                rd_j = j_reg + 4'd1;
            end
            else
            begin
                rd_j = j_reg;
                rd_k = k_reg + 4'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        rd_data_reg <= mem[mat_addr(rd_j, rd_k)];
    end

    // coefficient ring: the active cells are head_idx .. NCELL-1
    assign a_head = a_cell[head_idx];
    assign t_head = t_cell[head_idx];
    assign a_en   = (accept && !is_mat) || (state_reg == S_MAC) || (state_reg == S_QSUM)
                    || out_load;
    assign t_en   = row_done || (state_reg == S_QSUM) || out_load;
    assign a_tail = (state_reg == S_IDLE) ? in_data.vector_value : a_head;
    assign t_tail = (state_reg == S_MAC) ? acc_sum : t_head;

    for (genvar i = 0; i < NCELL; i++)
    begin : g_cell
        if (i == NCELL - 1)
        begin : g_tail
            rqg_cell u_cell (
                .clk   (clk),
                .a_en  (a_en),
                .a_in  (a_tail),
                .t_en  (t_en),
                .t_in  (t_tail),
                .a_out (a_cell[i]),
                .t_out (t_cell[i])
            );
        end
        else
        begin : g_mid
            rqg_cell u_cell (
                .clk   (clk),
                .a_en  (a_en),
                .a_in  (a_cell[i+1]),
                .t_en  (t_en),
                .t_in  (t_cell[i+1]),
                .a_out (a_cell[i]),
                .t_out (t_cell[i])
            );
        end
    end

    // datapath
    always_comb
    begin
        prod_sa = rd_data_reg * a_head;
        prod_aa = a_head * a_head;
        acc_sum = acc_reg + TW'(prod_sa);
        prod_at = a_head * t_head;
        q_abs   = q_reg[QW-1] ? QW'(-q_reg) : QW'(q_reg);
        r_new   = q_reg[QW-1] ? -$signed(div_quot[RW-1:0]) : $signed(div_quot[RW-1:0]);
        f_wide  = $signed((RW+1)'(1) <<< 30) - (RW+1)'(r_reg);
        if (f_wide > (RW+1)'(32'sh7fffffff))
        begin
            f_sat = 32'sh7fffffff;
        end
        else if (f_wide < -$signed((RW+1)'(33'h80000000)))
        begin
            f_sat = 32'sh80000000;
        end
        else
        begin
            f_sat = f_wide[31:0];
        end
        num     = ($signed(NW'(t_head)) <<< 15) - ar_reg;
        num_abs = num[NW-1] ? NW'(-num) : NW'(num);
        if (neg_reg)
        begin
            g_sat = (div_quot > DW'(32'h7fffffff)) ? 32'sh7fffffff : $signed(div_quot[31:0]);
        end
        else
        begin
            g_sat = (div_quot > DW'(33'h80000000)) ? 32'sh80000000
                                                  : -$signed(div_quot[31:0]);
        end
    end

    always_comb
    begin
        div_req.start    = (state_reg == S_RDIV) || (state_reg == S_GNUM);
        div_req.divisor  = n_reg;
        div_req.dividend = (state_reg == S_RDIV) ? DW'({q_abs, 15'b0}) : DW'({num_abs, 10'b0});
    end

    rqg_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .done  (div_done),
        .quot  (div_quot)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            vlen_reg      <= 5'd16;
            count_reg     <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            row_reg       <= '0;
            col_reg       <= '0;
            mval_reg      <= '0;
            acc_reg       <= '0;
            n_reg         <= '0;
            q_reg         <= '0;
            r_reg         <= '0;
            f_reg         <= '0;
            ar_reg        <= '0;
            neg_reg       <= 1'b0;
            g_reg         <= '0;
            zero_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            if (out_valid_reg && out_ready && !out_load)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_write)
            begin
                vlen_reg  <= cfg_data;
                count_reg <= '0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (accept && is_mat)
                    begin
                        row_reg  <= in_data.row_index;
                        col_reg  <= in_data.col_index;
                        mval_reg <= in_data.matrix_value;
                        if (in_range)
                        begin
                            state_reg <= S_WR2;
                        end
                    end
                    else if (accept)
                    begin
                        if (run_start)
                        begin
                            count_reg <= '0;
                            j_reg     <= '0;
                            k_reg     <= '0;
                            acc_reg   <= '0;
                            n_reg     <= '0;
                            q_reg     <= '0;
                            state_reg <= S_MAC;
                        end
                        else
                        begin
                            count_reg <= cnt_eff + 5'd1;
                        end
                    end
                end
                S_WR2:
                begin
                    state_reg <= S_IDLE;
                end
                S_MAC:
                begin
                    if (j_reg == 4'd0)
                    begin
                        n_reg <= n_reg + VW'($unsigned(prod_aa));
                    end
                    if (k_reg == last_idx)
                    begin
                        acc_reg <= '0;
                        k_reg   <= '0;
                        if (j_reg == last_idx)
                        begin
                            j_reg     <= '0;
                            state_reg <= S_QSUM;
                        end
                        else
                        begin
                            j_reg <= j_reg + 4'd1;
                        end
                    end
                    else
                    begin
                        acc_reg <= acc_sum;
                        k_reg   <= k_reg + 4'd1;
                    end
                end
                S_QSUM:
                begin
                    q_reg <= q_reg + QW'(prod_at);
                    if (j_reg == last_idx)
                    begin
                        j_reg <= '0;
                        if (n_reg == '0)
                        begin
                            zero_reg  <= 1'b1;
                            state_reg <= S_GOUT;
                        end
                        else
                        begin
                            zero_reg  <= 1'b0;
                            state_reg <= S_RDIV;
                        end
                    end
                    else
                    begin
                        j_reg <= j_reg + 4'd1;
                    end
                end
                S_RDIV:
                begin
                    state_reg <= S_RWAIT;
                end
                S_RWAIT:
                begin
                    if (div_done)
                    begin
                        r_reg     <= r_new;
                        state_reg <= S_GMUL;
                    end
                end
                S_GMUL:
                begin
                    ar_reg    <= NW'(a_head * r_reg);
                    f_reg     <= f_sat;
                    state_reg <= S_GNUM;
                end
                S_GNUM:
                begin
                    neg_reg   <= num[NW-1];
                    state_reg <= S_GWAIT;
                end
                S_GWAIT:
                begin
                    if (div_done)
                    begin
                        g_reg     <= g_sat;
                        state_reg <= S_GOUT;
                    end
                end
                S_GOUT:
                begin
                    if (out_load)
                    begin
                        out_valid_reg                <= 1'b1;
                        out_data_reg.element_index   <= j_reg;
                        out_data_reg.gradient_value  <= zero_reg ? 32'sd0 : g_reg;
                        out_data_reg.objective_value <= zero_reg ? 32'sd0 : f_reg;
                        out_data_reg.zero_norm       <= zero_reg;
                        out_data_reg.last_result     <= (j_reg == last_idx);
                        if (j_reg == last_idx)
                        begin
                            j_reg     <= '0;
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            j_reg     <= j_reg + 4'd1;
                            state_reg <= zero_reg ? S_GOUT : S_GMUL;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_count_below_len: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> count_reg < len)
        else $error("element count not below run length");

    a_run_enters_mac: assert property (@(posedge clk) disable iff (!rst_n)
        run_start && !cfg_write |=> state_reg == S_MAC)
        else $error("last coefficient did not start the row products");

    a_zero_flag_norm: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_GOUT |-> zero_reg == (n_reg == '0))
        else $error("zero norm flag disagrees with norm");

    a_div_only_when_norm: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> n_reg != '0)
        else $error("divider started with zero norm");
endmodule
`default_nettype wire

@@ dv/rqg_checker.sv @@
// rqg_checker: watches the config, input and output channels of the rayleigh quotient block
// predicts gradient words per run and compares them; depends on rqg_pkg
`default_nettype none
module rqg_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic [4:0]         cfg_data,
    input  logic               in_valid,
    input  logic               in_ready,
    input  rqg_pkg::in_word_t  in_data,
    input  logic               out_valid,
    input  logic               out_ready,
    input  rqg_pkg::out_word_t out_data,
    output int                 errors,
    output int                 pending
);
    import rqg_pkg::*;

    shortint   overlap [16][16];
    shortint   coef [16];
    int        coef_count;
    int        vec_len;
    out_word_t grad_q [$];

    function automatic longint sat32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    task automatic report(string what, longint got, longint want);
        $display("mismatch %s: got %0d, want %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // gradient words for the run that just closed
    task automatic predict_gradients(int len);
        longint    t [16];
        longint    q;
        longint    n;
        longint    r;
        longint    f;
        longint    acc;
        longint    uq;
        longint    mag;
        longint    num;
        longint    g;
        out_word_t w;
        q = 0;
        n = 0;
        r = 0;
        f = 0;
        for (int j = 0; j < len; j++)
        begin
            acc = 0;
            for (int k = 0; k < len; k++)
                acc += longint'(overlap[j][k]) * longint'(coef[k]);
            t[j] = acc;
            q += longint'(coef[j]) * acc;
            n += longint'(coef[j]) * longint'(coef[j]);
        end
        if (n != 0)
        begin
            uq  = (q < 0) ? -q : q;
            mag = (uq / n) * 32768 + ((uq % n) * 32768) / n;
            r   = (q < 0) ? -mag : mag;
            f   = sat32((64'sd1 << 30) - r);
        end
        for (int j = 0; j < len; j++)
        begin
            g = 0;
            if (n != 0)
            begin
                num = t[j] * 32768 - longint'(coef[j]) * r;
                g   = sat32(-((num * 1024) / n));
            end
            w.element_index   = j[3:0];
            w.gradient_value  = g[31:0];
            w.objective_value = f[31:0];
            w.zero_norm       = (n == 0);
            w.last_result     = (j == len - 1);
            grad_q.push_back(w);
        end
    endtask

    task automatic take_input(in_word_t w);
        int len;
        len = (vec_len < 1) ? 1 : (vec_len > 16 ? 16 : vec_len);
        if (w.req_type == REQ_MATRIX)
        begin
            overlap[w.row_index][w.col_index] = w.matrix_value;
            overlap[w.col_index][w.row_index] = w.matrix_value;
        end
        else
        begin
            if (coef_count >= len)
                coef_count = len - 1;
            coef[coef_count] = w.vector_value;
            coef_count++;
            if (coef_count >= len)
            begin
                coef_count = 0;
                predict_gradients(len);
            end
        end
    endtask

    task automatic check_output(out_word_t got);
        out_word_t want;
        if (grad_q.size() == 0)
        begin
            report("unexpected word, index", got.element_index, -1);
        end
        else
        begin
            want = grad_q.pop_front();
            if (got.element_index !== want.element_index)
                report("element_index", got.element_index, want.element_index);
            if (got.gradient_value !== want.gradient_value)
                report("gradient_value", got.gradient_value, want.gradient_value);
            if (got.objective_value !== want.objective_value)
                report("objective_value", got.objective_value, want.objective_value);
            if (got.zero_norm !== want.zero_norm)
                report("zero_norm", got.zero_norm, want.zero_norm);
            if (got.last_result !== want.last_result)
                report("last_result", got.last_result, want.last_result);
        end
    endtask

    initial
    begin
        for (int i = 0; i < 16; i++)
        begin
            coef[i] = 0;
            for (int k = 0; k < 16; k++)
                overlap[i][k] = 0;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            errors     = 0;
            vec_len    = 16;
            coef_count = 0;
        end
        else
        begin
            if (cfg_write)
            begin
                vec_len    = cfg_data;
                coef_count = 0;
            end
            if (in_valid && in_ready)
                take_input(in_data);
            if (out_valid && out_ready)
                check_output(out_data);
        end
        pending = grad_q.size();
    end
endmodule
`default_nettype wire

@@ dv/tb_top.sv @@
// tb_top: stimulus and verdict for rayleigh_quotient_gradient_top
// depends on rqg_pkg, the block and rqg_checker
`default_nettype none
module tb_top;
    import rqg_pkg::*;

    localparam int STALL_LIMIT = 40000;

    logic      clk;
    logic      rst_n;
    logic      cfg_write;
    logic [4:0] cfg_data;
    logic      in_valid;
    logic      in_ready;
    in_word_t  in_data;
    logic      out_valid;
    logic      out_ready;
    out_word_t out_data;
    logic      in_fire;
    int        errors;
    int        pending;
    int        in_idle;
    int        out_idle;
    int        quiet;

    rayleigh_quotient_gradient_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    rqg_checker chk (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .errors    (errors),
        .pending   (pending)
    );

    initial
        clk = 1'b0;
    always #5 clk = ~clk;

    // accept seen at the last rising edge, read by the driver at the falling edge
    always @(posedge clk)
    begin
        if (!rst_n)
            in_fire <= 1'b0;
        else
            in_fire <= in_valid && in_ready;
    end

    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= out_idle);

    always @(posedge clk)
    begin
        if (!rst_n)
            quiet <= 0;
        else if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= STALL_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic send(in_word_t w);
        int gap;
        gap = 0;
        while ($urandom_range(99) < in_idle)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        do
            @(negedge clk);
        while (!in_fire);
    endtask

    task automatic send_mat(int r, int c, logic [15:0] v);
        in_word_t w;
        w.req_type     = REQ_MATRIX;
        w.row_index    = r[3:0];
        w.col_index    = c[3:0];
        w.matrix_value = v;
        w.vector_value = 16'($urandom);
        send(w);
    endtask

    task automatic send_vec(logic [15:0] v);
        in_word_t w;
        w.req_type     = REQ_VECTOR;
        w.row_index    = 4'($urandom);
        w.col_index    = 4'($urandom);
        w.matrix_value = 16'($urandom);
        w.vector_value = v;
        send(w);
    endtask

    // block is idle once every word is out and a matrix write has settled
    task automatic wait_idle(int extra);
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (extra) @(negedge clk);
    endtask

    task automatic set_len(logic [4:0] len);
        wait_idle(20);
        cfg_write <= 1'b1;
        cfg_data  <= len;
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    function automatic logic [15:0] rand_coef();
        int m;
        m = $urandom_range(9);
        if (m == 0)
            return 16'h0000;
        if (m < 4)
            return 16'($signed($urandom_range(64)) - 32);
        if (m == 4)
            return ($urandom_range(1)) ? 16'h7fff : 16'h8000;
        return 16'($urandom);
    endfunction

    initial
    begin
        int len;
        rst_n     = 1'b0;
        cfg_write = 1'b0;
        cfg_data  = '0;
        in_valid  = 1'b0;
        in_data   = '0;
        in_idle   = 8;
        out_idle  = 80;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // fill the whole matrix so no run reads an unwritten entry
        for (int r = 0; r < 16; r++)
            for (int c = r; c < 16; c++)
                send_mat(r, c, (r == c) ? 16'h7fff : (c == 15 ? 16'h8000 : 16'($urandom)));

        // reset length of 16 with extreme coefficients
        for (int j = 0; j < 16; j++)
            send_vec((j % 2) ? 16'h8000 : 16'h7fff);
        set_len(5'd1);
        send_vec(16'h7fff);
        send_vec(16'h8000);
        send_vec(16'h0000);
        set_len(5'd0);
        send_vec(16'h0001);
        set_len(5'd3);
        repeat (3) send_vec(16'h0000);
        // matrix write in the middle of a run
        set_len(5'd2);
        send_vec(16'h0001);
        send_mat(1, 0, 16'h7fff);
        send_vec(16'h0000);
        set_len(5'd31);
        for (int j = 0; j < 16; j++)
            send_vec(j == 0 ? 16'h0001 : 16'h0000);

        for (int phase = 0; phase < 3; phase++)
        begin
            wait_idle(20);
            in_idle  = (phase == 0) ? 8 : (phase == 1 ? 80 : 0);
            out_idle = (phase == 0) ? 80 : (phase == 1 ? 8 : 0);
            for (int s = 0; s < 4; s++)
            begin
                case ($urandom_range(9))
                    0:       len = 16;
                    1:       len = 0;
                    2:       len = 31;
                    default: len = $urandom_range(1, 4);
                endcase
                set_len(len[4:0]);
                for (int i = 0; i < 24; i++)
                begin
                    if ($urandom_range(4) == 0)
                        send_mat($urandom_range(15), $urandom_range(15), 16'($urandom));
                    else
                        send_vec(rand_coef());
                end
            end
        end

        wait_idle(400);
        if (errors == 0 && pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
`default_nettype wire

@@ files.f @@
rtl/rqg_pkg.sv
rtl/rqg_cell.sv
rtl/rqg_div.sv
rtl/rayleigh_quotient_gradient_top.sv
dv/rqg_checker.sv
dv/tb_top.sv
